// ===== rtl/catmull_rom_loop_eval_assert.svh =====
// Assertion macros for the closed-loop Catmull-Rom evaluator.
// Depends on nothing; included by the files that carry assertions.
`ifndef CATMULL_ROM_LOOP_EVAL_ASSERT_SVH
`define CATMULL_ROM_LOOP_EVAL_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on the rising edge, skipped while reset is high.
`define CRLE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed")
// Check a property on the rising edge, also during reset.
`define CRLE_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed")
`else
`define CRLE_ASSERT(lbl, clk, rst, prop)
`define CRLE_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/crle_pkg.sv =====
// Shared types and constants of the closed-loop Catmull-Rom evaluator.
// Depends on nothing; used by catmull_rom_loop_eval.
package crle_pkg;

   localparam int COORD_WIDTH    = 32;
   localparam int PARAM_BITS     = 16;
   localparam int CFG_W          = 7;
   localparam int POINT_INDEX_W  = 6;
   localparam int DEF_MAX_POINTS = 64;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;

   localparam logic [CFG_W-1:0] ACTIVE_POINTS_RESET = 7'd4;

   // register index, taken from the word address of the configuration port
   localparam logic [CSR_ADDR_W-3:0] REG_ACTIVE_POINTS = 1'b0;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_EVAL  = 1'b1;

   typedef struct packed {
      logic                          cmd;
      logic [POINT_INDEX_W-1:0]      point_index;
      logic signed [COORD_WIDTH-1:0] coord_x;
      logic signed [COORD_WIDTH-1:0] coord_y;
      logic signed [COORD_WIDTH-1:0] coord_z;
      logic [PARAM_BITS-1:0]         global_param;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] pos_x;
      logic signed [COORD_WIDTH-1:0] pos_y;
      logic signed [COORD_WIDTH-1:0] pos_z;
      logic signed [COORD_WIDTH-1:0] deriv_x;
      logic signed [COORD_WIDTH-1:0] deriv_y;
      logic signed [COORD_WIDTH-1:0] deriv_z;
   } rsp_type;

endpackage

// ===== rtl/catmull_rom_loop_eval.sv =====
// Closed uniform Catmull-Rom loop evaluator: point store, sequencer, shared multiplier.
// Depends on crle_pkg and catmull_rom_loop_eval_assert.svh.
//
//   channel   handshake                       beat
//   -------   -----------------------------   ---------------------------------
//   request   start && !busy                  req_data  (crle_pkg::req_type)
//   result    rsp_valid, one cycle, no stall  rsp_data  (crle_pkg::rsp_type)
//   config    psel && penable && pwrite       paddr / pwdata, prdata on read
//
// A write beat stores its point at the accepting edge and leaves the block idle.
// An evaluate beat keeps busy high while it forms segment and local t, reads the
// four neighbours through the single read port of the store, and then, per axis,
// forms the basis terms and runs 5 Horner steps, each a multiply and an add, on
// the one multiplier. The result strobe comes in the cycle busy drops, which can
// also take the next beat, so a new beat is taken only after the last evaluation
// is through. Reset is synchronous; it clears the sequencer and sets active_points
// to 4. The point store is not cleared. The receiver cannot stall results.
`include "catmull_rom_loop_eval_assert.svh"

module catmull_rom_loop_eval #(
   parameter int MAX_POINTS = crle_pkg::DEF_MAX_POINTS
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                start,
   output logic                                busy,
   input  crle_pkg::req_type                   req_data,
   // result channel
   output logic                                rsp_valid,
   output crle_pkg::rsp_type                   rsp_data,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [crle_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [crle_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [crle_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   localparam int CW     = crle_pkg::COORD_WIDTH;
   localparam int PB     = crle_pkg::PARAM_BITS;
   localparam int IDX_W  = $clog2(MAX_POINTS);
   // wide enough for the point count, the config value and any slot number
   localparam int CMP_W  = (IDX_W + 1 > crle_pkg::CFG_W) ? IDX_W + 1 : crle_pkg::CFG_W;
   // Horner accumulator: derivative terms reach 50 times a coordinate
   localparam int ACC_W  = CW + 7;
   localparam int MB_W   = PB + 1;
   localparam int PW     = ACC_W + MB_W;
   localparam int AXES   = 3;

   localparam logic [2:0] LOAD_LAST = 3'd4;
   localparam logic [1:0] AXIS_LAST = 2'(AXES - 1);
   localparam logic signed [PW-1:0] RND_HALF = PW'(2 ** (PB - 1));

   typedef enum logic [2:0] {
      ST_IDLE, ST_SEG_MUL, ST_SEG_IDX, ST_LOAD, ST_COEF, ST_MUL, ST_ADD, ST_SAT
   } state_type;

   // Horner step: which addend follows the rounded product
   typedef enum logic [2:0] {
      STEP_POS_A2, STEP_POS_A1, STEP_POS_A0, STEP_DER_A2, STEP_DER_A1
   } step_type;

   state_type  state_ff;
   step_type   step_ff;
   logic       rsp_valid_ff;

   logic [crle_pkg::CFG_W-1:0] active_ff;
   logic [CMP_W-1:0]           n_ff;
   logic [PB-1:0]              param_ff;
   logic [PB-1:0]              u_ff;
   logic [IDX_W-1:0]           ptr_ff;
   logic [2:0]                 ld_cnt_ff;
   logic [1:0]                 axis_ff;

   logic [AXES*CW-1:0]         mem [MAX_POINTS];
   logic [AXES*CW-1:0]         rd_ff;
   logic [AXES*CW-1:0]         p_ff [4];

   logic signed [ACC_W-1:0]    acc_ff, a3_ff, a2_ff, a1_ff, a0_ff;
   logic signed [PW-1:0]       prod_ff;
   logic signed [CW-1:0]       pos_ff [AXES];
   logic signed [CW-1:0]       der_ff [AXES];

   // ---------------------------------------------------------------------------
   // handshake and configuration decode
   // ---------------------------------------------------------------------------
   logic accept, wr_hit, cfg_wr, cfg_sel_active;
   logic [CMP_W-1:0] slot_ext;
   logic [CMP_W-1:0] act_ext;
   logic [CMP_W-1:0] n_in;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign pready    = 1'b1;
   assign rsp_valid = rsp_valid_ff;

   assign cfg_sel_active = (paddr[crle_pkg::CSR_ADDR_W-1:2] == crle_pkg::REG_ACTIVE_POINTS);
   assign cfg_wr         = psel && penable && pwrite && pready;
   assign prdata = cfg_sel_active ? crle_pkg::CSR_DATA_W'(active_ff) : '0;

   // drop writes to slots beyond the store
   assign slot_ext = CMP_W'(req_data.point_index);
   assign wr_hit   = accept && (req_data.cmd == crle_pkg::CMD_WRITE)
                     && (slot_ext < CMP_W'(MAX_POINTS));

   // a count of zero acts as one, a count past the store as the store size
   assign act_ext = CMP_W'(active_ff);
   always_comb begin
      n_in = act_ext;
      if (act_ext == '0) begin
         n_in = CMP_W'(1);
      end else if (act_ext > CMP_W'(MAX_POINTS)) begin
         n_in = CMP_W'(MAX_POINTS);
      end
   end

   // ---------------------------------------------------------------------------
   // point store: one write port for request beats, one registered read port
   // ---------------------------------------------------------------------------
   logic rd_en;
   assign rd_en = (state_ff == ST_LOAD) && (ld_cnt_ff != LOAD_LAST);

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         mem[slot_ext[IDX_W-1:0]] <= {req_data.coord_z, req_data.coord_y, req_data.coord_x};
      end
      if (rd_en) begin
         rd_ff <= mem[ptr_ff];
      end
   end

   // ---------------------------------------------------------------------------
   // shared multiplier: segment scaling, then every Horner product
   // ---------------------------------------------------------------------------
   logic signed [ACC_W-1:0] mul_a;
   logic signed [MB_W-1:0]  mul_b;
   logic signed [PW-1:0]    mul_out;

   always_comb begin
      if (state_ff == ST_SEG_MUL) begin
         mul_a = ACC_W'(param_ff);
         mul_b = MB_W'(n_ff);
      end else begin
         mul_a = acc_ff;
         mul_b = {1'b0, u_ff};
      end
   end
   assign mul_out = mul_a * mul_b;

   // segment from the integer part, first neighbour one slot back with wrap
   logic [CMP_W-1:0] seg_v, idx0_v, ptr_ext;
   logic [IDX_W-1:0] ptr_next;

   assign seg_v   = prod_ff[PB +: CMP_W];
   assign idx0_v  = (seg_v == '0) ? n_ff - CMP_W'(1) : seg_v - CMP_W'(1);
   assign ptr_ext = CMP_W'(ptr_ff);
   assign ptr_next = (ptr_ext == n_ff - CMP_W'(1)) ? '0 : ptr_ff + IDX_W'(1);

   logic [1:0] ld_slot;
   assign ld_slot = 2'(ld_cnt_ff - 3'd1);

   // ---------------------------------------------------------------------------
   // basis coefficients of the current axis (doubled, exact)
   // ---------------------------------------------------------------------------
   logic signed [CW-1:0]    pa [4];
   logic signed [ACC_W-1:0] e  [4];
   logic signed [ACC_W-1:0] d12, a3_in, a2_in, a1_in, a0_in;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         pa[k] = p_ff[k][int'(axis_ff) * CW +: CW];
         e[k]  = ACC_W'(pa[k]);
      end
      d12   = e[1] - e[2];
      a3_in = (e[3] - e[0]) + d12 + (d12 <<< 1);
      a2_in = (e[0] <<< 1) - e[1] - (e[1] <<< 2) + (e[2] <<< 2) - e[3];
      a1_in = e[2] - e[0];
      a0_in = e[1] <<< 1;
   end

   // ---------------------------------------------------------------------------
   // Horner step: round the product half up, add the next term
   // ---------------------------------------------------------------------------
   logic signed [PW-1:0]    rnd_sum, rnd_sh;
   logic signed [ACC_W-1:0] addend, acc_in;

   always_comb begin
      case (step_ff)
         STEP_POS_A2: addend = a2_ff;
         STEP_POS_A1: addend = a1_ff;
         STEP_POS_A0: addend = a0_ff;
         STEP_DER_A2: addend = a2_ff <<< 1;
         STEP_DER_A1: addend = a1_ff;
         default:     addend = a1_ff;
      endcase
   end

   assign rnd_sum = prod_ff + RND_HALF;
   assign rnd_sh  = rnd_sum >>> PB;
   assign acc_in  = rnd_sh[ACC_W-1:0] + addend;

   // halve the doubled value with rounding, then clamp to the coordinate range
   function automatic logic signed [CW-1:0] sat_half(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] h;
      logic [ACC_W-CW:0]       top;
      h   = (v + ACC_W'(1)) >>> 1;
      top = h[ACC_W-1:CW-1];
      if ((top == '0) || (top == '1)) begin
         return h[CW-1:0];
      end else if (h[ACC_W-1]) begin
         return {1'b1, {(CW-1){1'b0}}};
      end else begin
         return {1'b0, {(CW-1){1'b1}}};
      end
   endfunction

   logic signed [CW-1:0] sat_in;
   assign sat_in = sat_half(acc_ff);

   // ---------------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         active_ff    <= crle_pkg::ACTIVE_POINTS_RESET;
      end else begin
         if (cfg_wr && cfg_sel_active) begin
            active_ff <= pwdata[crle_pkg::CFG_W-1:0];
         end
         case (state_ff)
            ST_IDLE: begin
               // the strobe lasts the single idle cycle after the last axis
               rsp_valid_ff <= 1'b0;
               // latch the count with the beat so a later write cannot skew it
               if (accept && (req_data.cmd == crle_pkg::CMD_EVAL)) begin
                  param_ff <= req_data.global_param;
                  n_ff     <= n_in;
                  state_ff <= ST_SEG_MUL;
               end
            end
            ST_SEG_MUL: begin
               prod_ff  <= mul_out;
               state_ff <= ST_SEG_IDX;
            end
            ST_SEG_IDX: begin
               u_ff      <= prod_ff[PB-1:0];
               ptr_ff    <= idx0_v[IDX_W-1:0];
               ld_cnt_ff <= '0;
               state_ff  <= ST_LOAD;
            end
            ST_LOAD: begin
               // issue a read per cycle, capture it from rd_ff in the following cycle
               if (ld_cnt_ff != 3'd0) begin
                  p_ff[ld_slot] <= rd_ff;
               end
               if (ld_cnt_ff == LOAD_LAST) begin
                  axis_ff  <= '0;
                  state_ff <= ST_COEF;
               end else begin
                  ptr_ff    <= ptr_next;
                  ld_cnt_ff <= ld_cnt_ff + 3'd1;
               end
            end
            ST_COEF: begin
               a3_ff    <= a3_in;
               a2_ff    <= a2_in;
               a1_ff    <= a1_in;
               a0_ff    <= a0_in;
               acc_ff   <= a3_in;
               step_ff  <= STEP_POS_A2;
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               prod_ff  <= mul_out;
               state_ff <= ST_ADD;
            end
            ST_ADD: begin
               acc_ff <= acc_in;
               case (step_ff)
                  STEP_POS_A2: begin
                     step_ff  <= STEP_POS_A1;
                     state_ff <= ST_MUL;
                  end
                  STEP_POS_A1: begin
                     step_ff  <= STEP_POS_A0;
                     state_ff <= ST_MUL;
                  end
                  STEP_DER_A2: begin
                     step_ff  <= STEP_DER_A1;
                     state_ff <= ST_MUL;
                  end
                  default: begin
                     state_ff <= ST_SAT;
                  end
               endcase
            end
            ST_SAT: begin
               if (step_ff == STEP_POS_A0) begin
                  // position done, start the derivative from 3*A3
                  pos_ff[axis_ff] <= sat_in;
                  acc_ff          <= a3_ff + (a3_ff <<< 1);
                  step_ff         <= STEP_DER_A2;
                  state_ff        <= ST_MUL;
               end else begin
                  der_ff[axis_ff] <= sat_in;
                  if (axis_ff == AXIS_LAST) begin
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end else begin
                     axis_ff  <= axis_ff + 2'd1;
                     state_ff <= ST_COEF;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_data.pos_x   = pos_ff[0];
   assign rsp_data.pos_y   = pos_ff[1];
   assign rsp_data.pos_z   = pos_ff[2];
   assign rsp_data.deriv_x = der_ff[0];
   assign rsp_data.deriv_y = der_ff[1];
   assign rsp_data.deriv_z = der_ff[2];

   // ---------------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------------
   `CRLE_ASSERT(a_strobe_single, clock, reset, rsp_valid |=> !rsp_valid);
   `CRLE_ASSERT(a_strobe_idle, clock, reset, rsp_valid |-> !busy);
   `CRLE_ASSERT(a_eval_goes_busy, clock, reset,
      (accept && (req_data.cmd == crle_pkg::CMD_EVAL)) |=> busy);
   `CRLE_ASSERT(a_write_no_result, clock, reset,
      (accept && (req_data.cmd == crle_pkg::CMD_WRITE)) |=> (!busy && !rsp_valid));
   `CRLE_ASSERT(a_ptr_in_loop, clock, reset, (state_ff == ST_LOAD) |-> (ptr_ext < n_ff));
   `CRLE_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!busy && !rsp_valid));

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for catmull_rom_loop_eval: loads control points, sweeps loop sizes,
// predicts every curve beat and compares it field by field. Depends on crle_pkg and the RTL.
module tb_top;
   import crle_pkg::*;

   // Index of a register the block does not implement; writes there must do nothing.
   localparam logic [CSR_ADDR_W-3:0] REG_SPARE = 1'b1;

   // Shadow of the block: point store, loop size and the curve beats still owed.
   class loop_curve_tracker;
      logic signed [COORD_WIDTH-1:0] store_x[DEF_MAX_POINTS];
      logic signed [COORD_WIDTH-1:0] store_y[DEF_MAX_POINTS];
      logic signed [COORD_WIDTH-1:0] store_z[DEF_MAX_POINTS];
      logic [CFG_W-1:0] active_points;
      rsp_type curve_points_due[$];
      int mismatch_count;
      string field_names[6] = '{"pos_x", "pos_y", "pos_z", "deriv_x", "deriv_y", "deriv_z"};

      function new();
         active_points = ACTIVE_POINTS_RESET;
         mismatch_count = 0;
      endfunction

      // Zero acts as one point, anything past the store size as the full store.
      static function int loop_size(logic [CFG_W-1:0] v);
         if (v == 0) return 1;
         if (v > DEF_MAX_POINTS) return DEF_MAX_POINTS;
         return int'(v);
      endfunction

      function void flag(string msg);
         mismatch_count++;
         if (mismatch_count <= 10) $display("%t mismatch: %s", $realtime, msg);
      endfunction

      // Round half up of h*u/2^16; arithmetic shift gives the floor.
      static function longint horner_step(longint h, longint u);
         return (h * u + 32768) >>> PARAM_BITS;
      endfunction

      static function logic signed [COORD_WIDTH-1:0] clamp_coord(longint v);
         if (v > 64'sd2147483647) return 32'sh7fffffff;
         if (v < -64'sd2147483648) return 32'sh80000000;
         return v[COORD_WIDTH-1:0];
      endfunction

      // Doubled basis coefficients, Horner on the position and on the derivative.
      static function void blend_axis(longint p0, longint p1, longint p2, longint p3,
                                      longint u, output logic signed [COORD_WIDTH-1:0] pos,
                                      output logic signed [COORD_WIDTH-1:0] der);
         longint a3, a2, a1, a0, h, g;
         a3 = -p0 + 3 * p1 - 3 * p2 + p3;
         a2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
         a1 = p2 - p0;
         a0 = 2 * p1;
         h = horner_step(a3, u) + a2;
         h = horner_step(h, u) + a1;
         h = horner_step(h, u) + a0;
         pos = clamp_coord((h + 1) >>> 1);
         g = horner_step(3 * a3, u) + 2 * a2;
         g = horner_step(g, u) + a1;
         der = clamp_coord((g + 1) >>> 1);
      endfunction

      function rsp_type predict_curve(req_type r);
         int n, i0, i1, i2, i3;
         longint prod, seg, u;
         rsp_type res;
         n = loop_size(active_points);
         prod = longint'(r.global_param) * n;
         seg = prod >>> PARAM_BITS;
         u = prod & 64'hffff;
         i0 = int'((seg + n - 1) % n);
         i1 = (i0 + 1) % n;
         i2 = (i1 + 1) % n;
         i3 = (i2 + 1) % n;
         blend_axis(store_x[i0], store_x[i1], store_x[i2], store_x[i3], u,
                    res.pos_x, res.deriv_x);
         blend_axis(store_y[i0], store_y[i1], store_y[i2], store_y[i3], u,
                    res.pos_y, res.deriv_y);
         blend_axis(store_z[i0], store_z[i1], store_z[i2], store_z[i3], u,
                    res.pos_z, res.deriv_z);
         return res;
      endfunction

      function void note_request(req_type r);
         if (r.cmd == CMD_WRITE) begin
            store_x[r.point_index] = r.coord_x;
            store_y[r.point_index] = r.coord_y;
            store_z[r.point_index] = r.coord_z;
         end else begin
            curve_points_due.push_back(predict_curve(r));
         end
      endfunction

      function void note_register(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
         if (addr[CSR_ADDR_W-1:2] == REG_ACTIVE_POINTS) active_points = data[CFG_W-1:0];
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         logic [5:0][COORD_WIDTH-1:0] g, w;
         if (curve_points_due.size() == 0) begin
            flag($sformatf("result beat with nothing pending: %h", got));
            return;
         end
         want = curve_points_due.pop_front();
         g = got;
         w = want;
         for (int i = 0; i < 6; i++)
            if (g[5-i] !== w[5-i])
               flag($sformatf("%s expected %h got %h", field_names[i], w[5-i], g[5-i]));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   loop_curve_tracker curve;
   bit                written_slot[DEF_MAX_POINTS];
   bit                idle_on;

   catmull_rom_loop_eval uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Sample everything at the edge that accepts it. Check the result first: a beat
   // accepted at the same edge belongs behind it in the queue.
   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (rsp_valid === 1'b1) curve.check_response(rsp_data);
         if (start === 1'b1 && busy === 1'b0) curve.note_request(req_data);
         if (psel && penable && pwrite && pready === 1'b1) curve.note_register(paddr, pwdata);
      end
   end

   // Mostly small coordinates so curves stay in range, plus full-range and rail values
   // that drive the outputs into saturation.
   function automatic logic [COORD_WIDTH-1:0] pick_coord();
      int spread;
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'h7fffffff;
               1: return 32'h80000000;
               2: return 32'h00000000;
               default: return 32'hffffffff;
            endcase
         end
         default: begin
            spread = $urandom_range(0, 1 << 22);
            return spread - (1 << 21);
         end
      endcase
   endfunction

   // Favor the first parameter of a segment and the one just before it.
   function automatic logic [PARAM_BITS-1:0] pick_param(int n);
      int k, p;
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hffff;
         2, 3: begin
            k = $urandom_range(0, n - 1);
            p = (k * 65536 + n - 1) / n - int'($urandom_range(0, 1));
            if (p < 0) p = 0;
            return p[PARAM_BITS-1:0];
         end
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type make_write(int slot, logic [31:0] x, logic [31:0] y,
                                          logic [31:0] z);
      req_type r;
      r.cmd          = CMD_WRITE;
      r.point_index  = slot[POINT_INDEX_W-1:0];
      r.coord_x      = x;
      r.coord_y      = y;
      r.coord_z      = z;
      r.global_param = 16'($urandom);
      return r;
   endfunction

   // Fill the unused fields with noise; the block must ignore them.
   function automatic req_type make_eval(logic [PARAM_BITS-1:0] p);
      req_type r;
      r.cmd          = CMD_EVAL;
      r.point_index  = POINT_INDEX_W'($urandom);
      r.coord_x      = $urandom;
      r.coord_y      = $urandom;
      r.coord_z      = $urandom;
      r.global_param = p;
      return r;
   endfunction

   // Offer one beat and hold it until accepted. Idle bursts lower start first; now
   // and then hold off until every curve beat owed has come back.
   task automatic send_beat(input req_type beat);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         if ($urandom_range(0, 30) == 0) begin
            do @(posedge clock); while (curve.curve_points_due.size() != 0);
         end else begin
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
      end
      start    <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (busy !== 1'b0);
      if (beat.cmd == CMD_WRITE) written_slot[beat.point_index] = 1'b1;
   endtask

   // Drop start and wait until the block is idle with nothing owed. A write finishes
   // at its accepting edge, so the wait for idle covers it too.
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (curve.curve_points_due.size() != 0 || busy !== 1'b0);
      repeat (4) @(posedge clock);
   endtask

   // Setup phase, then access until pready; psel drops before the next transfer.
   task automatic csr_access(input bit is_write, input logic [CSR_ADDR_W-3:0] reg_idx,
                             input logic [CSR_DATA_W-1:0] value,
                             output logic [CSR_DATA_W-1:0] rd);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      rd = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Write every slot the current loop reaches that has never been loaded.
   task automatic fill_loop(input int n);
      for (int i = 0; i < n; i++)
         if (!written_slot[i]) send_beat(make_write(i, pick_coord(), pick_coord(), pick_coord()));
   endtask

   initial begin
      logic [CFG_W-1:0]      loop_plan[10];
      logic [CSR_DATA_W-1:0] rd;
      int                    n;

      curve    = new();
      start   <= 1'b0;
      req_data <= '0;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= '0;
      pwdata  <= '0;
      reset   <= 1'b1;
      idle_on  = 1'b1;
      repeat (7) @(posedge clock);
      reset   <= 1'b0;

      // Reset loop of four points with x and y at the coordinate rails, plus the top slot.
      send_beat(make_write(0, 32'h7fffffff, 32'h80000000, 32'h00000000));
      send_beat(make_write(1, 32'h80000000, 32'h7fffffff, 32'hffffffff));
      send_beat(make_write(2, 32'h7fffffff, 32'h7fffffff, 32'h00010000));
      send_beat(make_write(3, 32'h80000000, 32'h80000000, 32'hfff00000));
      send_beat(make_write(63, 32'h00018000, 32'hffff8000, 32'h12345678));
      // Parameter ends and both sides of a segment boundary.
      send_beat(make_eval(16'h0000));
      send_beat(make_eval(16'hffff));
      send_beat(make_eval(16'h4000));
      send_beat(make_eval(16'h3fff));
      send_beat(make_eval(16'h8000));
      send_beat(make_eval(16'h0001));

      // A write to an unimplemented register must leave the loop size alone.
      settle();
      csr_access(1'b1, REG_SPARE, 32'h0000_0011, rd);
      send_beat(make_eval(16'hc000));

      // Loop size zero behaves as a single point.
      settle();
      csr_access(1'b1, REG_ACTIVE_POINTS, 32'h0000_0000, rd);
      send_beat(make_eval(16'h0000));
      send_beat(make_eval(16'hffff));
      send_beat(make_eval(16'h8000));

      // Random phases over several loop sizes, including sizes past the store.
      loop_plan = '{7'd64, 7'd127, 7'd1, 7'd2, 7'd3, 7'd5, 7'd37, 7'd100, 7'd0, 7'd64};
      loop_plan[8] = CFG_W'($urandom_range(0, 127));
      for (int ph = 0; ph < 10; ph++) begin
         idle_on = (ph < 9);
         settle();
         if ($urandom_range(0, 2) == 0) csr_access(1'b1, REG_SPARE, $urandom, rd);
         // Upper data bits are noise; only the low field is kept.
         csr_access(1'b1, REG_ACTIVE_POINTS,
                    {(CSR_DATA_W - CFG_W)'($urandom), loop_plan[ph]}, rd);
         csr_access(1'b0, REG_ACTIVE_POINTS, '0, rd);
         if (rd !== CSR_DATA_W'(curve.active_points))
            curve.flag($sformatf("active_points read %h expected %h", rd, curve.active_points));
         n = loop_curve_tracker::loop_size(loop_plan[ph]);
         fill_loop(n);
         for (int i = 0; i < 50; i++) begin
            if ($urandom_range(0, 9) < 6)
               send_beat(make_eval(pick_param(n)));
            else
               send_beat(make_write($urandom_range(0, DEF_MAX_POINTS - 1),
                                    pick_coord(), pick_coord(), pick_coord()));
         end
      end

      // Drain, then give one full evaluation time for any stray beat to show up.
      start <= 1'b0;
      while (curve.curve_points_due.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (curve.mismatch_count == 0 && curve.curve_points_due.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Hard stop: end the run with an error if it has not finished.
   initial begin
      #4_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
